// ===== hdl/nhpwl_pkg.sv =====
// ----------------------------------------------------------------------------
// nhpwl_pkg
// Types and constants shared by the wirelength accumulator modules.
// ----------------------------------------------------------------------------
package nhpwl_pkg;

  localparam int unsigned LOC_W   = 24;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned COORD_W = 28;
  localparam int unsigned LEN_W   = 29;
  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned CFG_W   = 24;

  typedef enum logic [1:0] {
    CFG_CLAMP_ENABLE = 2'd0,
    CFG_X_LIMIT      = 2'd1,
    CFG_Y_LIMIT      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [LOC_W-1:0]        cell_x;
    logic [LOC_W-1:0]        cell_y;
    logic [LOC_W-1:0]        cell_width;
    logic [LOC_W-1:0]        cell_height;
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
    logic                    is_terminal;
    logic                    last_pin_of_net;
    logic                    last_net;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0]   net_length;
    logic [TOTAL_W-1:0] total_length;
    logic               design_done;
  } out_t;

  // pin point on its way into the bounding box
  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      last_pin;
    logic                      last_net;
  } pin_pt_t;

  // spans of a finished net
  typedef struct packed {
    logic [COORD_W-1:0] span_x;
    logic [COORD_W-1:0] span_y;
    logic               design_done;
  } span_t;

endpackage

// ===== hdl/nhpwl_coord.sv =====
// ----------------------------------------------------------------------------
// nhpwl_coord
// One axis of the pin point: optional clamp, half size, scaled Q1.15 offset.
// ----------------------------------------------------------------------------
module nhpwl_coord (
  input  logic [nhpwl_pkg::LOC_W-1:0]          loc,
  input  logic [nhpwl_pkg::LOC_W-1:0]          size,
  input  logic signed [nhpwl_pkg::OFF_W-1:0]   off,
  input  logic [nhpwl_pkg::LOC_W-1:0]          limit,
  input  logic                                 clamp,
  output logic signed [nhpwl_pkg::COORD_W-1:0] pt
);

  logic [nhpwl_pkg::LOC_W-1:0] loc_c;
  logic signed [40:0]          prod;
  logic [24:0]                 scaled;

  assign loc_c  = (clamp && (loc > limit)) ? limit : loc;
  assign prod   = off * $signed({1'b0, size});
  // arithmetic shift by 15, floor toward minus infinity
  assign scaled = prod[39:15];
  assign pt     = $signed({4'b0, loc_c} + {5'b0, size[23:1]} + {{3{scaled[24]}}, scaled});

endmodule

// ===== hdl/nhpwl_box.sv =====
// ----------------------------------------------------------------------------
// nhpwl_box
// Running bounding box of the current net and the span stage register.
// ----------------------------------------------------------------------------
module nhpwl_box (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pt_valid,
  input  nhpwl_pkg::pin_pt_t  pt,
  output logic                pt_ready,
  output logic                span_valid,
  output nhpwl_pkg::span_t    span,
  input  logic                span_ready
);

  logic signed [nhpwl_pkg::COORD_W-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic signed [nhpwl_pkg::COORD_W-1:0] min_x_nxt, max_x_nxt, min_y_nxt, max_y_nxt;
  logic signed [nhpwl_pkg::COORD_W-1:0] ext_min_x, ext_max_x, ext_min_y, ext_max_y;
  logic                                 has_r, has_nxt;
  logic                                 valid_r, valid_nxt;
  nhpwl_pkg::span_t                     span_r, span_nxt;
  logic                                 stage_rdy;
  logic                                 take;

  assign stage_rdy = !valid_r || span_ready;
  // a pin that does not close its net never needs the span stage
  assign pt_ready  = !pt.last_pin || stage_rdy;
  assign take      = pt_valid && pt_ready;

  always_comb begin
    ext_min_x = (!has_r || (pt.px < min_x_r)) ? pt.px : min_x_r;
    ext_max_x = (!has_r || (pt.px > max_x_r)) ? pt.px : max_x_r;
    ext_min_y = (!has_r || (pt.py < min_y_r)) ? pt.py : min_y_r;
    ext_max_y = (!has_r || (pt.py > max_y_r)) ? pt.py : max_y_r;

    min_x_nxt = min_x_r;
    max_x_nxt = max_x_r;
    min_y_nxt = min_y_r;
    max_y_nxt = max_y_r;
    has_nxt   = has_r;
    span_nxt  = span_r;
    valid_nxt = span_ready ? 1'b0 : valid_r;

    if (take) begin
      if (pt.last_pin) begin
        min_x_nxt            = '0;
        max_x_nxt            = '0;
        min_y_nxt            = '0;
        max_y_nxt            = '0;
        has_nxt              = 1'b0;
        span_nxt.span_x      = ext_max_x - ext_min_x;
        span_nxt.span_y      = ext_max_y - ext_min_y;
        span_nxt.design_done = pt.last_net;
        valid_nxt            = 1'b1;
      end else begin
        min_x_nxt = ext_min_x;
        max_x_nxt = ext_max_x;
        min_y_nxt = ext_min_y;
        max_y_nxt = ext_max_y;
        has_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0;
      max_x_r <= '0;
      min_y_r <= '0;
      max_y_r <= '0;
      has_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      min_x_r <= min_x_nxt;
      max_x_r <= max_x_nxt;
      min_y_r <= min_y_nxt;
      max_y_r <= max_y_nxt;
      has_r   <= has_nxt;
      valid_r <= valid_nxt;
    end
    span_r <= span_nxt;
  end

  assign span_valid = valid_r;
  assign span       = span_r;

endmodule

// ===== hdl/nhpwl_total.sv =====
// ----------------------------------------------------------------------------
// nhpwl_total
// Net length stage, saturating running total and the result register.
// ----------------------------------------------------------------------------
module nhpwl_total (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              span_valid,
  input  nhpwl_pkg::span_t  span,
  output logic              span_ready,
  output logic              out_valid,
  output nhpwl_pkg::out_t   out_data,
  input  logic              out_ready
);

  logic                              len_v_r, len_v_nxt;
  logic [nhpwl_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic                              done_r, done_nxt;
  logic [nhpwl_pkg::TOTAL_W-1:0]     sum_r, sum_nxt;
  logic                              out_valid_r, out_valid_nxt;
  nhpwl_pkg::out_t                   out_r, out_nxt;
  logic [nhpwl_pkg::TOTAL_W:0]       sum_wide;
  logic [nhpwl_pkg::TOTAL_W-1:0]     sum_sat;
  logic                              out_rdy;
  logic                              move;

  assign out_rdy    = !out_valid_r || out_ready;
  assign span_ready = !len_v_r || out_rdy;
  assign move       = len_v_r && out_rdy;

  assign sum_wide = {1'b0, sum_r} + {20'b0, len_r};
  assign sum_sat  = sum_wide[nhpwl_pkg::TOTAL_W] ? '1 : sum_wide[nhpwl_pkg::TOTAL_W-1:0];

  always_comb begin
    len_v_nxt     = out_rdy ? 1'b0 : len_v_r;
    len_nxt       = len_r;
    done_nxt      = done_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_nxt       = out_r;

    if (span_valid && span_ready) begin
      len_v_nxt = 1'b1;
      len_nxt   = {1'b0, span.span_x} + {1'b0, span.span_y};
      done_nxt  = span.design_done;
    end

    if (move) begin
      out_valid_nxt        = 1'b1;
      out_nxt.net_length   = len_r;
      out_nxt.total_length = sum_sat;
      out_nxt.design_done  = done_r;
      // total restarts after the design's last net
      sum_nxt              = done_r ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_v_r     <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_v_r     <= len_v_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r  <= len_nxt;
    done_r <= done_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/netlist_hpwl_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// netlist_hpwl_accumulator_unit
// Half-perimeter wirelength of a pin stream, per net and as a running total.
// ----------------------------------------------------------------------------
// Pins arrive on the in_ channel (valid/ready), net by net; last_pin_of_net
// closes a net and last_net with it closes the design. Each closed net gives
// one transfer on the out_ channel with the net's x plus y span, the
// saturating total so far, and design_done. Other pins give no result.
// The cfg_ channel writes clamp_enable, x_limit and y_limit and is always
// ready. The user writes it only while the block is idle; it is not enforced.
// One pin per cycle is accepted while in_ready stays high. The point math
// sits in the point stage, the bounding box compare loop in the span stage,
// then the net length stage and the total add into the result register. The
// one-cycle rate is set by the box min/max feedback loop.
// Reset clears the box, the total, all stage valids and the registers to
// their defaults (clamping off, limits all ones).
// When out_ready stays low the result register holds and the stages behind
// it fill up; in_ready drops once no stage can move, and pins that do not
// close a net keep flowing into the box while the span stage waits.
// ----------------------------------------------------------------------------
module netlist_hpwl_accumulator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  nhpwl_pkg::in_t               in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output nhpwl_pkg::out_t              out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [nhpwl_pkg::CFG_W-1:0]  cfg_data
);

  logic                           clamp_en_r, clamp_en_nxt;
  logic [nhpwl_pkg::LOC_W-1:0]    x_limit_r, x_limit_nxt;
  logic [nhpwl_pkg::LOC_W-1:0]    y_limit_r, y_limit_nxt;

  logic                           in_v_r, in_v_nxt;
  nhpwl_pkg::in_t                 in_r, in_nxt;
  logic                           pt_v_r, pt_v_nxt;
  nhpwl_pkg::pin_pt_t             pt_r, pt_nxt;
  logic                           pt_ready;
  logic                           pt_rdy;
  logic                           clamp;
  logic signed [nhpwl_pkg::COORD_W-1:0] px, py;

  logic                           span_valid;
  nhpwl_pkg::span_t               span;
  logic                           span_ready;

  assign cfg_ready = 1'b1;

  always_comb begin
    clamp_en_nxt = clamp_en_r;
    x_limit_nxt  = x_limit_r;
    y_limit_nxt  = y_limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nhpwl_pkg::CFG_CLAMP_ENABLE: clamp_en_nxt = cfg_data[0];
        nhpwl_pkg::CFG_X_LIMIT:      x_limit_nxt  = cfg_data;
        nhpwl_pkg::CFG_Y_LIMIT:      y_limit_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stage handshake
  assign pt_rdy   = !pt_v_r || pt_ready;
  assign in_ready = !in_v_r || pt_rdy;

  assign clamp = clamp_en_r && in_r.is_terminal;

  nhpwl_coord u_coord_x (
    .loc   (in_r.cell_x),
    .size  (in_r.cell_width),
    .off   (in_r.offset_x),
    .limit (x_limit_r),
    .clamp (clamp),
    .pt    (px)
  );

  nhpwl_coord u_coord_y (
    .loc   (in_r.cell_y),
    .size  (in_r.cell_height),
    .off   (in_r.offset_y),
    .limit (y_limit_r),
    .clamp (clamp),
    .pt    (py)
  );

  always_comb begin
    in_v_nxt = pt_rdy ? 1'b0 : in_v_r;
    in_nxt   = in_r;
    pt_v_nxt = pt_rdy ? in_v_r : pt_v_r;
    pt_nxt   = pt_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
      in_nxt   = in_data;
    end
    if (in_v_r && pt_rdy) begin
      pt_nxt.px       = px;
      pt_nxt.py       = py;
      pt_nxt.last_pin = in_r.last_pin_of_net;
      pt_nxt.last_net = in_r.last_net;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_en_r <= 1'b0;
      x_limit_r  <= '1;
      y_limit_r  <= '1;
      in_v_r     <= 1'b0;
      pt_v_r     <= 1'b0;
    end else begin
      clamp_en_r <= clamp_en_nxt;
      x_limit_r  <= x_limit_nxt;
      y_limit_r  <= y_limit_nxt;
      in_v_r     <= in_v_nxt;
      pt_v_r     <= pt_v_nxt;
    end
    in_r <= in_nxt;
    pt_r <= pt_nxt;
  end

  nhpwl_box u_box (
    .clk        (clk),
    .rst_n      (rst_n),
    .pt_valid   (pt_v_r),
    .pt         (pt_r),
    .pt_ready   (pt_ready),
    .span_valid (span_valid),
    .span       (span),
    .span_ready (span_ready)
  );

  nhpwl_total u_total (
    .clk        (clk),
    .rst_n      (rst_n),
    .span_valid (span_valid),
    .span       (span),
    .span_ready (span_ready),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_ready  (out_ready)
  );

endmodule

// ===== hdl/nhpwl_checker.sv =====
// ----------------------------------------------------------------------------
// nhpwl_checker
// Port-level checks of the wirelength accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module nhpwl_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             out_valid,
  input  logic             out_ready,
  input  nhpwl_pkg::out_t  out_data
);

  // next result is the first net of a new design
  logic fresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      fresh_r <= out_data.design_done;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_total_covers_net: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.total_length >= {19'b0, out_data.net_length})
    else $error("total below its own net length");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fresh_r |-> out_data.total_length == {19'b0, out_data.net_length})
    else $error("total not restarted after design end");

endmodule

bind netlist_hpwl_accumulator_unit nhpwl_checker u_nhpwl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
